// ===== design/permutation_rank_unrank_defines.svh =====
// assertion macros used by the permutation rank / unrank top-level design file
`ifndef PERMUTATION_RANK_UNRANK_DEFINES_SVH
`define PERMUTATION_RANK_UNRANK_DEFINES_SVH

`ifndef ASSERT_OFF

// property checked at every rising clock edge outside reset
`define PRU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define PRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`PRU_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define PRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	`PRU_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`else

`define PRU_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/pru_pkg.sv =====
// types, constants and helper functions of the permutation rank / unrank block
package pru_pkg;

	localparam int MAX_ELEMS      = 12;
	localparam int N_ELEMENTS_DEF = 12;
	localparam int NIB_W          = 4;
	localparam int PERM_W         = NIB_W * MAX_ELEMS;
	localparam int RANK_W         = 29;
	localparam int POS_W          = 4;
	localparam int RECIP_W        = 30;
	localparam int PROD_W         = RANK_W + RECIP_W;
	localparam int VAL_SET_W      = 1 << NIB_W;

	typedef logic [NIB_W-1:0] nib_t;
	typedef nib_t [MAX_ELEMS-1:0] perm_t;
	typedef logic [RANK_W-1:0] rank_t;

	typedef enum logic {
		KIND_RANK   = 1'b0,
		KIND_UNRANK = 1'b1
	} kind_t;

	// k! for the weights of the factorial number system
	function automatic rank_t fact(input int k);
		rank_t f;
		case (k)
			0:       f = rank_t'(1);
			1:       f = rank_t'(1);
			2:       f = rank_t'(2);
			3:       f = rank_t'(6);
			4:       f = rank_t'(24);
			5:       f = rank_t'(120);
			6:       f = rank_t'(720);
			7:       f = rank_t'(5040);
			8:       f = rank_t'(40320);
			9:       f = rank_t'(362880);
			10:      f = rank_t'(3628800);
			11:      f = rank_t'(39916800);
			12:      f = rank_t'(479001600);
			default: f = '0;
		endcase
		return f;
	endfunction

	// reciprocal floor(2^(29+l)/d)+1 with l = ceil(log2 d), exact for any 29-bit dividend
	function automatic logic [RECIP_W-1:0] recip_mult(input int d);
		logic [RECIP_W-1:0] m;
		case (d)
			2:       m = RECIP_W'(536870913);
			3:       m = RECIP_W'(715827883);
			4:       m = RECIP_W'(536870913);
			5:       m = RECIP_W'(858993460);
			6:       m = RECIP_W'(715827883);
			7:       m = RECIP_W'(613566757);
			8:       m = RECIP_W'(536870913);
			9:       m = RECIP_W'(954437177);
			10:      m = RECIP_W'(858993460);
			11:      m = RECIP_W'(780903145);
			12:      m = RECIP_W'(715827883);
			default: m = '0;
		endcase
		return m;
	endfunction

	// shift that goes with recip_mult
	function automatic int recip_shift(input int d);
		int s;
		case (d)
			2:       s = RANK_W + 1;
			3, 4:    s = RANK_W + 2;
			5, 6, 7, 8: s = RANK_W + 3;
			default: s = RANK_W + 4;
		endcase
		return s;
	endfunction

	// place digit+1 at pos and bump every later element that is equal or larger
	function automatic perm_t insert_digit(input perm_t vals, input int pos, input nib_t dig,
		input int n);
		perm_t res;
		nib_t  val;
		val = dig + NIB_W'(1);
		res = vals;
		for (int j = 0; j < MAX_ELEMS; j++) begin
			if (j > pos && j < n && vals[j] >= val) begin
				res[j] = vals[j] + NIB_W'(1);
			end
		end
		res[pos[POS_W-1:0]] = val;
		return res;
	endfunction

endpackage

// ===== design/pru_in_if.sv =====
// input channel: one rank or unrank request per item
interface pru_in_if;
	import pru_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [PERM_W-1:0] perm_word;
	logic [RANK_W-1:0] rank_in;

	modport source (output valid, output kind, output perm_word, output rank_in, input ready);
	modport sink (input valid, input kind, input perm_word, input rank_in, output ready);
endinterface

// ===== design/pru_out_if.sv =====
// output channel: one rank or permutation per item
interface pru_out_if;
	import pru_pkg::*;

	logic              valid;
	logic              ready;
	logic [RANK_W-1:0] rank_out;
	logic [PERM_W-1:0] perm_word_out;

	modport source (output valid, output rank_out, output perm_word_out, input ready);
	modport sink (input valid, input rank_out, input perm_word_out, output ready);
endinterface

// ===== design/permutation_rank_unrank.sv =====
// Permutation rank / unrank unit (Lehmer code, lexicographic order). Takes one item per clock
// cycle and returns exactly one result per item, in order. Rank mode: N_ELEMENTS-1 lanes
// each count the later elements smaller than their own, weight the count by its factorial,
// and a registered adder tree sums the lanes. Unrank mode: a chain of N_ELEMENTS-1 steps,
// each a 29x30 reciprocal multiply and a remainder, peels the mixed-radix digits off the
// index and inserts them into the permutation lanes; indices of N_ELEMENTS! or more wrap.
// After the entry register, a result passes the chain of two-stage unrank steps, the
// final insert register and the output register; the rank path is delayed to match.
// An item that waited in the input skid register enters from there. Output back-pressure
// stalls the whole pipeline; one item is still taken into the skid register while a
// result waits. No memories, no start-up sweep.
`include "permutation_rank_unrank_defines.svh"

module permutation_rank_unrank #(
	parameter int N_ELEMENTS = pru_pkg::N_ELEMENTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pru_in_if.sink    perm_req,
	pru_out_if.source perm_rsp
);
	import pru_pkg::*;

	localparam int LANES    = N_ELEMENTS - 1;
	localparam int STEPS    = N_ELEMENTS - 1;
	localparam int TREE_LVL = $clog2(LANES);
	localparam int UNR_LAT  = 2 * STEPS + 1;
	localparam int RANK_LAT = 1 + TREE_LVL;
	localparam int RANK_PAD = UNR_LAT - RANK_LAT;

	localparam rank_t                  FACT_N   = fact(N_ELEMENTS);
	localparam logic [VAL_SET_W-1:0]   VAL_MASK = VAL_SET_W'((32'(1) << (N_ELEMENTS + 1)) - 2);

	logic  en;

	logic  skid_valid_q;
	kind_t skid_kind_q;
	perm_t skid_perm_q;
	rank_t skid_rank_q;

	logic  vld_s1;
	kind_t kind_s1;
	perm_t perm_s1;
	rank_t rank_s1;

	logic [UNR_LAT-1:0] vld_dly_q;
	kind_t              kind_dly_q [UNR_LAT];

	rank_t [LANES-1:0]  lane_term;
	rank_t              rank_sum;
	rank_t              rank_dly_q [RANK_PAD];

	rank_t idx_c  [STEPS+1];
	perm_t vals_c [STEPS+1];
	nib_t  dig_c  [STEPS+1];
	perm_t perm_fin_q;

	logic  out_valid_q;
	rank_t rank_out_q;
	perm_t perm_out_q;

	// the pipeline moves unless a result waits at the output
	assign en             = !out_valid_q || perm_rsp.ready;
	assign perm_req.ready = !skid_valid_q;

	// skid register catches one item during a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (perm_req.valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && !skid_valid_q) begin
			skid_kind_q <= kind_t'(perm_req.kind);
			skid_perm_q <= perm_req.perm_word;
			skid_rank_q <= perm_req.rank_in;
		end
	end

	// entry stage, fed from the skid register first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= skid_valid_q || perm_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (skid_valid_q) begin
				kind_s1 <= skid_kind_q;
				perm_s1 <= skid_perm_q;
				rank_s1 <= skid_rank_q;
			end else begin
				kind_s1 <= kind_t'(perm_req.kind);
				perm_s1 <= perm_req.perm_word;
				rank_s1 <= perm_req.rank_in;
			end
		end
	end

	// item valid and mode travel alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly_q <= '0;
		end else if (en) begin
			vld_dly_q <= {vld_dly_q[UNR_LAT-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_dly_q[0] <= kind_s1;
			for (int k = 1; k < UNR_LAT; k++) begin
				kind_dly_q[k] <= kind_dly_q[k-1];
			end
		end
	end

	// rank lanes, one per position but the last
	for (genvar p = 0; p < LANES; p++) begin : g_lane
		pru_rank_lane #(
			.N_ELEMENTS(N_ELEMENTS),
			.POS       (p)
		) u_lane (
			.clk   (clk),
			.en    (en),
			.perm  (perm_s1),
			.term_q(lane_term[p])
		);
	end

	pru_rank_merge #(
		.N_ELEMENTS(N_ELEMENTS)
	) u_merge (
		.clk  (clk),
		.en   (en),
		.terms(lane_term),
		.sum  (rank_sum)
	);

	// rank waits for the longer unrank path
	always_ff @(posedge clk) begin
		if (en) begin
			rank_dly_q[0] <= rank_sum;
			for (int k = 1; k < RANK_PAD; k++) begin
				rank_dly_q[k] <= rank_dly_q[k-1];
			end
		end
	end

	// unrank chain; the last element starts as digit zero, so it becomes 1
	assign idx_c[0]  = rank_s1;
	assign vals_c[0] = '0;
	assign dig_c[0]  = '0;

	for (genvar t = 1; t <= STEPS; t++) begin : g_step
		pru_unrank_step #(
			.N_ELEMENTS(N_ELEMENTS),
			.STEP      (t)
		) u_step (
			.clk    (clk),
			.en     (en),
			.idx    (idx_c[t-1]),
			.vals   (vals_c[t-1]),
			.dig    (dig_c[t-1]),
			.idx_s2 (idx_c[t]),
			.vals_s2(vals_c[t]),
			.dig_s2 (dig_c[t])
		);
	end

	// first position takes the last digit; the leftover quotient is dropped
	always_ff @(posedge clk) begin
		if (en) begin
			perm_fin_q <= insert_digit(vals_c[STEPS], 0, dig_c[STEPS], N_ELEMENTS);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_dly_q[UNR_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (kind_dly_q[UNR_LAT-1] == KIND_UNRANK) begin
				rank_out_q <= '0;
				perm_out_q <= perm_fin_q;
			end else begin
				rank_out_q <= rank_dly_q[RANK_PAD-1];
				perm_out_q <= '0;
			end
		end
	end

	assign perm_rsp.valid         = out_valid_q;
	assign perm_rsp.rank_out      = rank_out_q;
	assign perm_rsp.perm_word_out = perm_out_q;

	// set of values held by the used positions
	function automatic logic [VAL_SET_W-1:0] val_set(input perm_t w);
		logic [VAL_SET_W-1:0] s;
		s = '0;
		for (int j = 0; j < N_ELEMENTS; j++) begin
			s[w[j]] = 1'b1;
		end
		return s;
	endfunction

	// checks
	`PRU_ASSERT_NXT(a_skid_drains, clk, arst_n, skid_valid_q && en, !skid_valid_q, "skid item left behind")
	`PRU_ASSERT_IMP(a_rank_bound, clk, arst_n, out_valid_q, rank_out_q < FACT_N, "rank out of range")
	`PRU_ASSERT_IMP(a_unrank_perm, clk, arst_n, out_valid_q && perm_out_q != '0, val_set(perm_out_q) == VAL_MASK && (perm_out_q >> (NIB_W * N_ELEMENTS)) == '0, "unrank result not a permutation")
endmodule

// ===== design/pru_rank_lane.sv =====
// one rank lane: counts later smaller elements and weights the count by its factorial
module pru_rank_lane #(
	parameter int N_ELEMENTS = pru_pkg::N_ELEMENTS_DEF,
	parameter int POS        = 0
) (
	input  logic           clk,
	input  logic           en,
	input  pru_pkg::perm_t perm,
	output pru_pkg::rank_t term_q
);
	import pru_pkg::*;

	localparam rank_t WEIGHT = fact(N_ELEMENTS - 1 - POS);

	logic [MAX_ELEMS-1:0] smaller;
	logic [POS_W-1:0]     cnt;
	rank_t                term;

	// compare this element with every later one
	always_comb begin
		smaller = '0;
		for (int j = 0; j < MAX_ELEMS; j++) begin
			if (j > POS && j < N_ELEMENTS) begin
				smaller[j] = perm[POS] > perm[j];
			end
		end
	end

	assign cnt  = POS_W'($countones(smaller));
	assign term = rank_t'(cnt) * WEIGHT;

	// lane register
	always_ff @(posedge clk) begin
		if (en) begin
			term_q <= term;
		end
	end
endmodule

// ===== design/pru_rank_merge.sv =====
// registered adder tree that merges the weighted lane counts into the rank
module pru_rank_merge #(
	parameter int N_ELEMENTS = pru_pkg::N_ELEMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  pru_pkg::rank_t [N_ELEMENTS-2:0]   terms,
	output pru_pkg::rank_t                    sum
);
	import pru_pkg::*;

	localparam int LANES  = N_ELEMENTS - 1;
	localparam int LVL    = $clog2(LANES);
	localparam int LEAVES = 1 << LVL;

	generate
		if (LVL == 0) begin : g_single
			// a single lane needs no merging
			assign sum = terms[0];
		end else begin : g_tree
			rank_t tree [1:2*LEAVES-1];
			rank_t node_q [1:LEAVES-1];

			// leaves, padded with zero up to a power of two
			for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
				if (i < LANES) begin : g_used
					assign tree[LEAVES+i] = terms[i];
				end else begin : g_pad
					assign tree[LEAVES+i] = '0;
				end
			end

			// one registered add per node, so each level of the tree is registered
			for (genvar k = 1; k < LEAVES; k++) begin : g_node
				always_ff @(posedge clk) begin
					if (en) begin
						node_q[k] <= tree[2*k] + tree[2*k+1];
					end
				end
				assign tree[k] = node_q[k];
			end

			assign sum = tree[1];
		end
	endgenerate
endmodule

// ===== design/pru_unrank_step.sv =====
// one unrank step: inserts the pending digit and splits the next digit off the index
module pru_unrank_step #(
	parameter int N_ELEMENTS = pru_pkg::N_ELEMENTS_DEF,
	parameter int STEP       = 1
) (
	input  logic           clk,
	input  logic           en,
	input  pru_pkg::rank_t idx,
	input  pru_pkg::perm_t vals,
	input  pru_pkg::nib_t  dig,
	output pru_pkg::rank_t idx_s2,
	output pru_pkg::perm_t vals_s2,
	output pru_pkg::nib_t  dig_s2
);
	import pru_pkg::*;

	localparam int                 DIV   = STEP + 1;
	localparam int                 POS   = N_ELEMENTS - STEP;
	localparam int                 SHIFT = recip_shift(DIV);
	localparam logic [RECIP_W-1:0] RECIP = recip_mult(DIV);

	logic [PROD_W-1:0] prod_s1;
	rank_t             idx_s1;
	perm_t             vals_s1;
	logic [PROD_W-1:0] quo;
	nib_t              quo_rad;

	// reciprocal multiply, element lanes take the pending digit
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(idx) * PROD_W'(RECIP);
			idx_s1  <= idx;
			vals_s1 <= insert_digit(vals, POS, dig, N_ELEMENTS);
		end
	end

	// quotient and remainder; the remainder fits in a nibble
	assign quo     = prod_s1 >> SHIFT;
	assign quo_rad = quo[NIB_W-1:0] * NIB_W'(DIV);

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2  <= quo[RANK_W-1:0];
			dig_s2  <= idx_s1[NIB_W-1:0] - quo_rad;
			vals_s2 <= vals_s1;
		end
	end
endmodule

// ===== sim/permutation_rank_unrank_tb.sv =====
// self-checking testbench of the permutation rank / unrank block
`timescale 1ns / 1ps

module permutation_rank_unrank_tb;
	import pru_pkg::*;

	localparam int ELEMS       = 12;
	localparam int DRAIN_CYC   = 2 * ELEMS + 8;
	localparam int LIMIT_CYC   = 200000;

	// one expected result
	typedef struct {
		logic [RANK_W-1:0] rank;
		logic [PERM_W-1:0] perm;
	} perm_result_t;

	logic clk;
	logic arst_n;
	logic idle_on;
	int   err_cnt;
	perm_result_t pending_q[$];

	pru_in_if  perm_req();
	pru_out_if perm_rsp();

	permutation_rank_unrank #(
		.N_ELEMENTS(ELEMS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.perm_req(perm_req),
		.perm_rsp(perm_rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// overall time limit
	initial begin
		#(LIMIT_CYC * 20);
		$display("Mismatches found");
		$finish;
	end

	// number of elements actually used
	function automatic int used_elems();
		int n;
		n = ELEMS;
		if (n > MAX_ELEMS) n = MAX_ELEMS;
		if (n < 1) n = 1;
		return n;
	endfunction

	// n! for the elements in use
	function automatic logic [63:0] num_perms();
		logic [63:0] f;
		f = 64'd1;
		for (int k = 2; k <= used_elems(); k++) f = f * 64'(k);
		return f;
	endfunction

	// lexicographic rank from the inversion counts, combined by mixed radix
	function automatic logic [RANK_W-1:0] lehmer_rank(input logic [PERM_W-1:0] pw);
		logic [63:0] acc;
		nib_t        v[MAX_ELEMS];
		int          n;
		n   = used_elems();
		acc = 64'd0;
		for (int i = 0; i < MAX_ELEMS; i++) v[i] = pw[NIB_W*i +: NIB_W];
		for (int i = 0; i + 1 < n; i++) begin
			acc = acc * 64'(n - i);
			for (int j = i + 1; j < n; j++) begin
				if (v[i] > v[j]) acc = acc + 64'd1;
			end
		end
		return acc[RANK_W-1:0];
	endfunction

	// permutation for an index, digits peeled from the back, later elements bumped up
	function automatic logic [PERM_W-1:0] lehmer_unrank(input logic [RANK_W-1:0] idx_in);
		logic [63:0]       idx;
		logic [63:0]       radix;
		logic [63:0]       digit;
		logic [7:0]        v[MAX_ELEMS];
		logic [PERM_W-1:0] w;
		int                n;
		int                i;
		n   = used_elems();
		idx = 64'(idx_in);
		for (int k = 0; k < MAX_ELEMS; k++) v[k] = 8'd0;
		v[n-1] = 8'd1;
		for (int k = n - 1; k > 0; k--) begin
			i     = k - 1;
			radix = 64'(n - i);
			digit = idx % radix;
			idx   = idx / radix;
			v[i]  = 8'd1 + digit[7:0];
			for (int j = i + 1; j < n; j++) begin
				if (v[j] >= v[i]) v[j] = v[j] + 8'd1;
			end
		end
		w = '0;
		for (int k = 0; k < n; k++) w[NIB_W*k +: NIB_W] = v[k][NIB_W-1:0];
		return w;
	endfunction

	// expected result of one item
	function automatic perm_result_t predict_result(input kind_t k,
		input logic [PERM_W-1:0] pw, input logic [RANK_W-1:0] ri);
		perm_result_t r;
		if (k == KIND_RANK) begin
			r.rank = lehmer_rank(pw);
			r.perm = '0;
		end else begin
			r.rank = '0;
			r.perm = lehmer_unrank(ri);
		end
		return r;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// random words
	function automatic logic [PERM_W-1:0] rand_word();
		return PERM_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [RANK_W-1:0] rand_rank_any();
		logic [31:0] r;
		r = $urandom();
		return r[RANK_W-1:0];
	endfunction

	function automatic logic [RANK_W-1:0] rand_rank_valid();
		logic [63:0] r;
		r = {$urandom(), $urandom()} % num_perms();
		return r[RANK_W-1:0];
	endfunction

	// shuffled well-formed permutation of 1..n
	function automatic logic [PERM_W-1:0] rand_perm();
		nib_t              v[MAX_ELEMS];
		nib_t              t;
		int                j;
		int                n;
		logic [PERM_W-1:0] w;
		n = used_elems();
		for (int i = 0; i < MAX_ELEMS; i++) v[i] = nib_t'(i + 1);
		for (int i = n - 1; i > 0; i--) begin
			j    = $urandom_range(0, i);
			t    = v[i];
			v[i] = v[j];
			v[j] = t;
		end
		w = '0;
		for (int i = 0; i < n; i++) w[NIB_W*i +: NIB_W] = v[i];
		return w;
	endfunction

	// drive one item and wait for it to be taken
	task automatic send_item(input kind_t k, input logic [PERM_W-1:0] pw,
		input logic [RANK_W-1:0] ri);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			perm_req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		perm_req.valid     <= 1'b1;
		perm_req.kind      <= k;
		perm_req.perm_word <= pw;
		perm_req.rank_in   <= ri;
		@(posedge clk);
		while (!perm_req.ready) @(posedge clk);
		pending_q.push_back(predict_result(k, pw, ri));
	endtask

	task automatic send_rank(input logic [PERM_W-1:0] pw);
		send_item(KIND_RANK, pw, rand_rank_any());
	endtask

	task automatic send_unrank(input logic [RANK_W-1:0] ri);
		send_item(KIND_UNRANK, rand_word(), ri);
	endtask

	// identity, reverse order and malformed words
	task automatic test_rank_directed();
		logic [PERM_W-1:0] ident;
		logic [PERM_W-1:0] rev;
		ident = '0;
		rev   = '0;
		for (int i = 0; i < ELEMS; i++) begin
			ident[NIB_W*i +: NIB_W] = nib_t'(i + 1);
			rev[NIB_W*i +: NIB_W]   = nib_t'(ELEMS - i);
		end
		send_rank(ident);
		send_rank(rev);
		send_rank('0);
		send_rank('1);
		// repeated values and out-of-range nibbles
		send_rank({(PERM_W / NIB_W){4'h5}});
		send_rank({ident[PERM_W-1:NIB_W], 4'hF});
		send_rank({4'h0, rev[PERM_W-NIB_W-1:0]});
		send_rank(48'h0F0F0F0F0F0F);
		// two neighbours swapped at the front and at the back
		send_rank({ident[PERM_W-1:2*NIB_W], ident[NIB_W-1:0], ident[2*NIB_W-1:NIB_W]});
		send_rank({ident[PERM_W-NIB_W-1:PERM_W-2*NIB_W], ident[PERM_W-1:PERM_W-NIB_W],
			ident[PERM_W-2*NIB_W-1:0]});
	endtask

	// index extremes and wrap past n!
	task automatic test_unrank_directed();
		logic [63:0] np;
		np = num_perms();
		send_unrank('0);
		send_unrank(RANK_W'(1));
		send_unrank(RANK_W'(np - 64'd1));
		send_unrank(RANK_W'(np));
		send_unrank(RANK_W'(np + 64'd1));
		send_unrank(RANK_W'(np + 64'd5));
		send_unrank('1);
		send_unrank(RANK_W'(np / 64'd2));
		send_unrank(RANK_W'(64'h1555_5555));
		send_unrank(RANK_W'(64'h0AAA_AAAA));
	endtask

	// mostly well-formed permutations, some noise words
	task automatic test_rank_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8) send_rank(rand_perm());
			else send_rank(rand_word());
		end
	endtask

	// mostly indices below n!, some over the whole field
	task automatic test_unrank_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 8) send_unrank(rand_rank_valid());
			else send_unrank(rand_rank_any());
		end
	endtask

	// both modes interleaved, with round trips through rank
	task automatic test_mixed_random(input int count);
		logic [PERM_W-1:0] pw;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: send_rank(rand_perm());
				1: send_unrank(rand_rank_valid());
				2: begin
					pw = lehmer_unrank(rand_rank_valid());
					send_rank(pw);
				end
				default: begin
					if ($urandom_range(0, 1) == 0) send_rank(rand_word());
					else send_unrank(rand_rank_any());
				end
			endcase
		end
	endtask

	// result side stalls in bursts
	initial begin
		int stall_left;
		stall_left     = 0;
		perm_rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				perm_rsp.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				stall_left     = $urandom_range(1, 5) - 1;
				perm_rsp.ready <= 1'b0;
			end else begin
				perm_rsp.ready <= 1'b1;
			end
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		perm_result_t want;
		if (arst_n && perm_rsp.valid && perm_rsp.ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result rank", 64'(perm_rsp.rank_out), 64'd0);
			end else begin
				want = pending_q.pop_front();
				if (perm_rsp.rank_out !== want.rank) begin
					report_mismatch("rank_out", 64'(perm_rsp.rank_out), 64'(want.rank));
				end
				if (perm_rsp.perm_word_out !== want.perm) begin
					report_mismatch("perm_word_out", 64'(perm_rsp.perm_word_out),
						64'(want.perm));
				end
			end
		end
	end

	// main sequence
	initial begin
		err_cnt            = 0;
		idle_on            = 1'b1;
		arst_n             <= 1'b0;
		perm_req.valid     <= 1'b0;
		perm_req.kind      <= KIND_RANK;
		perm_req.perm_word <= '0;
		perm_req.rank_in   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_rank_directed();
		test_unrank_directed();
		test_rank_random(300);
		test_unrank_random(300);
		test_mixed_random(300);
		// last part back to back, no idling
		idle_on = 1'b0;
		test_mixed_random(150);
		perm_req.valid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (err_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
